### design/lav_pkg.sv
package lav_pkg;

  // Default word and fraction widths of the fixed-point format.
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // The largest normalized magnitude lies in [2^(VEC_BITS-1), 2^VEC_BITS).
  localparam int VEC_BITS = 30;

  // Square root: one root bit per stage over a 2*SQRT_STEPS bit radicand.
  localparam int SQRT_STEPS = 32;

  typedef enum logic [1:0] {
    ROW_SIDE = 2'd0,
    ROW_UP   = 2'd1,
    ROW_FWD  = 2'd2
  } row_e;

endpackage

### design/lav_norm.sv
// Pipelined vector normalizer: scale, square, root one bit per stage,
// divide one quotient bit per stage. A side tag rides along with each vector.
module lav_norm #(
  parameter int MAG_BITS  = lav_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
  parameter int TAG_BITS  = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [2:0]                    neg_i,
  input  logic [2:0][MAG_BITS-1:0]      mag_i,
  input  logic [TAG_BITS-1:0]           tag_i,
  output logic                          valid_o,
  output logic                          ok_o,
  output logic [2:0][FRAC_BITS+1:0]     vec_o,
  output logic [TAG_BITS-1:0]           tag_o
);

  localparam int VB     = lav_pkg::VEC_BITS;
  localparam int NSQ    = lav_pkg::SQRT_STEPS;
  localparam int SQW    = 2 * NSQ;
  localparam int RB     = NSQ;
  localparam int PW     = $clog2(MAG_BITS + 1);
  localparam int SHW    = MAG_BITS + VB;
  localparam int NDIV   = FRAC_BITS + 1;
  localparam int REMW   = RB + FRAC_BITS;
  localparam int EW     = FRAC_BITS + 2;
  localparam int NST    = NSQ + NDIV + 7;
  localparam int SIDE_W = 1 + 3 + 3 * VB + TAG_BITS;
  localparam int V_LO   = TAG_BITS;
  localparam int N_LO   = TAG_BITS + 3 * VB;

  logic [NST-1:0] vld_q;

  // stage A: capture
  logic [2:0][MAG_BITS-1:0] a_mag_q;
  logic [2:0]               a_neg_q;
  logic [TAG_BITS-1:0]      a_tag_q;

  // stage B: leading one of the largest magnitude
  logic [MAG_BITS-1:0]      a_or;
  logic [PW-1:0]            b_p_d, b_p_q;
  logic [2:0][MAG_BITS-1:0] b_mag_q;
  logic [2:0]               b_neg_q;
  logic [TAG_BITS-1:0]      b_tag_q;
  logic                     b_nz_q;

  // stage C onward: side data
  logic [PW:0]              sh_amt;
  logic [SHW-1:0]           sh_full [3];
  logic [SIDE_W-1:0]        c_side_d;
  logic [SIDE_W-1:0]        side_q [2:NST-2];

  logic [2:0][2*VB-1:0]     d_sq_q;
  logic [SQW-1:0]           rt_rem_q [NSQ+1];
  logic [SQW-1:0]           rt_res_q [NSQ+1];

  logic [RB-1:0]            g_r;
  logic [2:0][REMW-1:0]     g_rem_d;
  logic [2:0][REMW-1:0]     dv_rem_q [NDIV+1];
  logic [2:0][NDIV-1:0]     dv_quo_q [NDIV+1];
  logic [RB-1:0]            dv_r_q   [NDIV+1];

  logic [2:0][EW-1:0]       h_vec_q;
  logic                     h_nz_q;
  logic [TAG_BITS-1:0]      h_tag_q;
  logic [SIDE_W-1:0]        h_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  always_comb begin
    a_or  = a_mag_q[0] | a_mag_q[1] | a_mag_q[2];
    b_p_d = '0;
    for (int i = 0; i < MAG_BITS; i++) begin
      if (a_or[i]) begin
        b_p_d = PW'(i);
      end
    end
  end

  // shift so that the leading one lands on bit VB-1
  always_comb begin
    sh_amt   = {1'b0, b_p_q} + (PW+1)'(1);
    c_side_d = '0;
    c_side_d[SIDE_W-1]          = b_nz_q;
    c_side_d[N_LO +: 3]         = b_neg_q;
    c_side_d[TAG_BITS-1:0]      = b_tag_q;
    for (int i = 0; i < 3; i++) begin
      sh_full[i] = {b_mag_q[i], {VB{1'b0}}} >> sh_amt;
      c_side_d[V_LO + i*VB +: VB] = sh_full[i][VB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_mag_q <= mag_i;
      a_neg_q <= neg_i;
      a_tag_q <= tag_i;
      b_mag_q <= a_mag_q;
      b_neg_q <= a_neg_q;
      b_tag_q <= a_tag_q;
      b_p_q   <= b_p_d;
      b_nz_q  <= (a_or != '0);
      side_q[2] <= c_side_d;
      for (int k = 3; k <= NST-2; k++) begin
        side_q[k] <= side_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        d_sq_q[i] <= side_q[2][V_LO + i*VB +: VB] * side_q[2][V_LO + i*VB +: VB];
      end
      rt_rem_q[0] <= SQW'(d_sq_q[0]) + SQW'(d_sq_q[1]) + SQW'(d_sq_q[2]);
      rt_res_q[0] <= '0;
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [SQW-1:0] bitv, trial, rem_d, res_d;
    always_comb begin
      bitv  = SQW'(1) << (SQW - 2 - 2*k);
      trial = rt_res_q[k] + bitv;
      if (rt_rem_q[k] >= trial) begin
        rem_d = rt_rem_q[k] - trial;
        res_d = (rt_res_q[k] >> 1) + bitv;
      end else begin
        rem_d = rt_rem_q[k];
        res_d = rt_res_q[k] >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rt_rem_q[k+1] <= rem_d;
        rt_res_q[k+1] <= res_d;
      end
    end
  end

  // dividend with half the root added for rounding
  always_comb begin
    g_r = rt_res_q[NSQ][RB-1:0];
    for (int i = 0; i < 3; i++) begin
      g_rem_d[i] = (REMW'(side_q[NSQ+4][V_LO + i*VB +: VB]) << FRAC_BITS)
                 + REMW'(g_r >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dv_rem_q[0] <= g_rem_d;
      dv_quo_q[0] <= '0;
      dv_r_q[0]   <= g_r;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [REMW-1:0]      dsr;
    logic [2:0][REMW-1:0] rem_d;
    logic [2:0][NDIV-1:0] quo_d;
    always_comb begin
      dsr = REMW'(dv_r_q[j]) << (NDIV - 1 - j);
      for (int c = 0; c < 3; c++) begin
        if (dv_rem_q[j][c] >= dsr) begin
          rem_d[c] = dv_rem_q[j][c] - dsr;
          quo_d[c] = dv_quo_q[j][c] | (NDIV'(1) << (NDIV - 1 - j));
        end else begin
          rem_d[c] = dv_rem_q[j][c];
          quo_d[c] = dv_quo_q[j][c];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dv_rem_q[j+1] <= rem_d;
        dv_quo_q[j+1] <= quo_d;
        dv_r_q[j+1]   <= dv_r_q[j];
      end
    end
  end

  assign h_side = side_q[NST-2];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        h_vec_q[i] <= h_side[N_LO + i] ? EW'(0) - {1'b0, dv_quo_q[NDIV][i]}
                                       : {1'b0, dv_quo_q[NDIV][i]};
      end
      h_nz_q  <= h_side[SIDE_W-1];
      h_tag_q <= h_side[TAG_BITS-1:0];
    end
  end

  assign valid_o = vld_q[NST-1];
  assign ok_o    = h_nz_q;
  assign vec_o   = h_vec_q;
  assign tag_o   = h_tag_q;

endmodule

### design/lav_rows.sv
// Row sequencer: hold one finished view and hand out its three rows.
module lav_rows #(
  parameter int WORD_BITS = lav_pkg::WORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [2:0][2:0][WORD_BITS-1:0]  rows_i,
  input  logic [2:0][WORD_BITS-1:0]       trans_i,
  input  logic                            degenerate_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      row_index_o,
  output logic [WORD_BITS-1:0]            col0_o,
  output logic [WORD_BITS-1:0]            col1_o,
  output logic [WORD_BITS-1:0]            col2_o,
  output logic [WORD_BITS-1:0]            col3_o,
  output logic                            degenerate_o,
  output logic                            last_o
);

  lav_pkg::row_e                   row_q, row_d;
  logic                            buf_vld_q, buf_vld_d;
  logic                            take;
  logic [2:0][2:0][WORD_BITS-1:0]  buf_rows_q;
  logic [2:0][WORD_BITS-1:0]       buf_trans_q;
  logic                            buf_deg_q;

  assign take = !buf_vld_q || (out_ready_i && row_q == lav_pkg::ROW_FWD);

  always_comb begin
    row_d     = row_q;
    buf_vld_d = buf_vld_q;
    if (take) begin
      row_d     = lav_pkg::ROW_SIDE;
      buf_vld_d = valid_i;
    end else if (out_ready_i) begin
      case (row_q)
        lav_pkg::ROW_SIDE: row_d = lav_pkg::ROW_UP;
        lav_pkg::ROW_UP:   row_d = lav_pkg::ROW_FWD;
        default:           row_d = lav_pkg::ROW_SIDE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= lav_pkg::ROW_SIDE;
      buf_vld_q <= 1'b0;
    end else begin
      row_q     <= row_d;
      buf_vld_q <= buf_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && valid_i) begin
      buf_rows_q  <= rows_i;
      buf_trans_q <= trans_i;
      buf_deg_q   <= degenerate_i;
    end
  end

  assign ready_o      = take;
  assign out_valid_o  = buf_vld_q;
  assign row_index_o  = row_q;
  assign col0_o       = buf_rows_q[row_q][0];
  assign col1_o       = buf_rows_q[row_q][1];
  assign col2_o       = buf_rows_q[row_q][2];
  assign col3_o       = buf_trans_q[row_q];
  assign degenerate_o = buf_deg_q;
  assign last_o       = (row_q == lav_pkg::ROW_FWD);

endmodule

### design/look_at_view_matrix.sv
// Camera view matrix builder.
// Input channel (in_valid_i / in_ready_o): one transaction carries eye,
// target and up, each three signed fixed-point words.
// Output channel (out_valid_o / out_ready_i): three transactions per view,
// rows side, true up and negated forward (row_index 0, 1, 2), each with the
// three rotation entries in col0..col2 and the translation in col3; last_o
// marks the third row. The constant bottom row is not sent.
// When a vector to normalize has zero length (target on eye, up zero or
// parallel to forward) the rows are identity rows with zero translation and
// degenerate_o is set.
// The delay from input transaction to the first row is set by three chained
// normalizers whose square root and divider retire one bit per stage. A new
// view can enter while earlier ones are still in flight; the view rate is
// bounded by the single result port, which sends the three rows one by one.
// Reset clears all valid bits; no rows are pending afterwards.
// A stalled receiver holds the current row; the pipeline keeps filling until
// its last stage is occupied, then in_ready_o drops. Nothing is lost.
module look_at_view_matrix #(
  parameter int WORD_BITS = lav_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_BITS-1:0] eye_x_i,
  input  logic [WORD_BITS-1:0] eye_y_i,
  input  logic [WORD_BITS-1:0] eye_z_i,
  input  logic [WORD_BITS-1:0] target_x_i,
  input  logic [WORD_BITS-1:0] target_y_i,
  input  logic [WORD_BITS-1:0] target_z_i,
  input  logic [WORD_BITS-1:0] up_x_i,
  input  logic [WORD_BITS-1:0] up_y_i,
  input  logic [WORD_BITS-1:0] up_z_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           row_index_o,
  output logic [WORD_BITS-1:0] col0_o,
  output logic [WORD_BITS-1:0] col1_o,
  output logic [WORD_BITS-1:0] col2_o,
  output logic [WORD_BITS-1:0] col3_o,
  output logic                 degenerate_o,
  output logic                 last_o
);

  localparam int W     = WORD_BITS;
  localparam int E     = FRAC_BITS + 2;      // unit vector component
  localparam int PXW   = 2 * E;              // cross product term
  localparam int MAGX  = 2 * FRAC_BITS + 2;  // cross product magnitude
  localparam int PTW   = E + W;              // entry times eye
  localparam int AW    = PTW + 2;            // translation accumulator
  localparam int SW    = AW - FRAC_BITS;
  localparam int TAG_S = 1 + 3*E + 3*W;
  localparam int TAG_U = 1 + 6*E + 3*W;

  logic adv;
  logic rows_ready;

  logic [2:0][W-1:0] eye_w, tgt_w, up_w;
  logic [2:0]        up_neg, dir_neg;
  logic [2:0][W-1:0] up_mag, dir_mag;

  assign eye_w = {eye_z_i, eye_y_i, eye_x_i};
  assign tgt_w = {target_z_i, target_y_i, target_x_i};
  assign up_w  = {up_z_i, up_y_i, up_x_i};

  // exact magnitudes of up and of target - eye
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up_neg[i] = up_w[i][W-1];
      up_mag[i] = up_neg[i] ? W'(0) - up_w[i] : up_w[i];
      dir_neg[i] = $signed(tgt_w[i]) < $signed(eye_w[i]);
      dir_mag[i] = dir_neg[i] ? eye_w[i] - tgt_w[i] : tgt_w[i] - eye_w[i];
    end
  end

  // first pair: normalized up and forward
  logic              nu_valid, f_valid, nu_ok, f_ok;
  logic [2:0][E-1:0] nu_vec, f_vec;
  logic [W-1:0]      nu_tag;
  logic [2*W-1:0]    f_tag;

  lav_norm #(.MAG_BITS(W), .FRAC_BITS(FRAC_BITS), .TAG_BITS(W)) u_norm_up (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(in_valid_i),
    .neg_i(up_neg), .mag_i(up_mag), .tag_i(eye_x_i),
    .valid_o(nu_valid), .ok_o(nu_ok), .vec_o(nu_vec), .tag_o(nu_tag)
  );

  lav_norm #(.MAG_BITS(W), .FRAC_BITS(FRAC_BITS), .TAG_BITS(2*W)) u_norm_fwd (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(in_valid_i),
    .neg_i(dir_neg), .mag_i(dir_mag), .tag_i({eye_z_i, eye_y_i}),
    .valid_o(f_valid), .ok_o(f_ok), .vec_o(f_vec), .tag_o(f_tag)
  );

  // cross f x nu
  logic                     x1_vld_q;
  logic [2:0][1:0][PXW-1:0] x1_prod_d, x1_prod_q;
  logic [2:0][W-1:0]        x1_eye_q;
  logic [2:0][E-1:0]        x1_f_q;
  logic                     x1_ok_q;

  for (genvar i = 0; i < 3; i++) begin : g_x1
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;
    assign x1_prod_d[i][0] = $signed(f_vec[I1]) * $signed(nu_vec[I2]);
    assign x1_prod_d[i][1] = $signed(f_vec[I2]) * $signed(nu_vec[I1]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_prod_q <= x1_prod_d;
      x1_eye_q  <= {f_tag, nu_tag};
      x1_f_q    <= f_vec;
      x1_ok_q   <= nu_ok & f_ok;
    end
  end

  logic [2:0][PXW:0]    x1_diff;
  logic [2:0]           s_neg_in;
  logic [2:0][MAGX-1:0] s_mag_in;
  logic [PXW:0]         x1_abs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x1_diff[i]  = {x1_prod_q[i][0][PXW-1], x1_prod_q[i][0]}
                  - {x1_prod_q[i][1][PXW-1], x1_prod_q[i][1]};
      s_neg_in[i] = x1_diff[i][PXW];
      x1_abs[i]   = s_neg_in[i] ? (PXW+1)'(0) - x1_diff[i] : x1_diff[i];
      s_mag_in[i] = x1_abs[i][MAGX-1:0];
    end
  end

  logic              s_valid, s_ok;
  logic [2:0][E-1:0] s_vec;
  logic [TAG_S-1:0]  s_tag;

  lav_norm #(.MAG_BITS(MAGX), .FRAC_BITS(FRAC_BITS), .TAG_BITS(TAG_S)) u_norm_side (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(x1_vld_q),
    .neg_i(s_neg_in), .mag_i(s_mag_in), .tag_i({x1_ok_q, x1_f_q, x1_eye_q}),
    .valid_o(s_valid), .ok_o(s_ok), .vec_o(s_vec), .tag_o(s_tag)
  );

  // cross s x f
  logic                     x2_vld_q;
  logic [2:0][E-1:0]        s_f;
  logic [2:0][1:0][PXW-1:0] x2_prod_d, x2_prod_q;
  logic [2:0][W-1:0]        x2_eye_q;
  logic [2:0][E-1:0]        x2_f_q, x2_s_q;
  logic                     x2_ok_q;

  assign s_f = s_tag[3*W +: 3*E];

  for (genvar i = 0; i < 3; i++) begin : g_x2
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;
    assign x2_prod_d[i][0] = $signed(s_vec[I1]) * $signed(s_f[I2]);
    assign x2_prod_d[i][1] = $signed(s_vec[I2]) * $signed(s_f[I1]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x2_prod_q <= x2_prod_d;
      x2_eye_q  <= s_tag[3*W-1:0];
      x2_f_q    <= s_f;
      x2_s_q    <= s_vec;
      x2_ok_q   <= s_tag[TAG_S-1] & s_ok;
    end
  end

  logic [2:0][PXW:0]    x2_diff;
  logic [2:0]           u_neg_in;
  logic [2:0][MAGX-1:0] u_mag_in;
  logic [PXW:0]         x2_abs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x2_diff[i]  = {x2_prod_q[i][0][PXW-1], x2_prod_q[i][0]}
                  - {x2_prod_q[i][1][PXW-1], x2_prod_q[i][1]};
      u_neg_in[i] = x2_diff[i][PXW];
      x2_abs[i]   = u_neg_in[i] ? (PXW+1)'(0) - x2_diff[i] : x2_diff[i];
      u_mag_in[i] = x2_abs[i][MAGX-1:0];
    end
  end

  logic              u_valid, u_ok;
  logic [2:0][E-1:0] u_vec;
  logic [TAG_U-1:0]  u_tag;

  lav_norm #(.MAG_BITS(MAGX), .FRAC_BITS(FRAC_BITS), .TAG_BITS(TAG_U)) u_norm_true_up (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(x2_vld_q),
    .neg_i(u_neg_in), .mag_i(u_mag_in),
    .tag_i({x2_ok_q, x2_s_q, x2_f_q, x2_eye_q}),
    .valid_o(u_valid), .ok_o(u_ok), .vec_o(u_vec), .tag_o(u_tag)
  );

  // translation: entry times eye per row; forward row negates at the sum
  logic [2:0][W-1:0]             u_eye;
  logic [2:0][E-1:0]             u_f, u_s;
  logic                          t1_vld_q, t1_ok_q;
  logic [2:0][2:0][E-1:0]        t1_row_q;
  logic [2:0][2:0][PTW-1:0]      t1_prod_q;

  assign u_eye = u_tag[3*W-1:0];
  assign u_f   = u_tag[3*W +: 3*E];
  assign u_s   = u_tag[3*W + 3*E +: 3*E];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_ok_q <= u_tag[TAG_U-1] & u_ok;
      for (int c = 0; c < 3; c++) begin
        t1_row_q[0][c]  <= u_s[c];
        t1_row_q[1][c]  <= u_vec[c];
        t1_row_q[2][c]  <= E'(0) - u_f[c];
        t1_prod_q[0][c] <= $signed(u_s[c]) * $signed(u_eye[c]);
        t1_prod_q[1][c] <= $signed(u_vec[c]) * $signed(u_eye[c]);
        t1_prod_q[2][c] <= $signed(u_f[c]) * $signed(u_eye[c]);
      end
    end
  end

  logic                   t2_vld_q, t2_ok_q;
  logic [2:0][2:0][E-1:0] t2_row_q;
  logic [2:0][AW-1:0]     t2_acc_q;
  logic [2:0][AW-1:0]     t2_sum;
  logic [AW-1:0]          half;

  assign half = AW'(1) << (FRAC_BITS - 1);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      t2_sum[r] = {{2{t1_prod_q[r][0][PTW-1]}}, t1_prod_q[r][0]}
                + {{2{t1_prod_q[r][1][PTW-1]}}, t1_prod_q[r][1]}
                + {{2{t1_prod_q[r][2][PTW-1]}}, t1_prod_q[r][2]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t2_ok_q     <= t1_ok_q;
      t2_row_q    <= t1_row_q;
      t2_acc_q[0] <= half - t2_sum[0];
      t2_acc_q[1] <= half - t2_sum[1];
      t2_acc_q[2] <= half + t2_sum[2];
    end
  end

  // floor shift, saturate, and swap in identity rows for a degenerate view
  logic [2:0][SW-1:0]     sh;
  logic [2:0][W-1:0]      trans;
  logic [2:0][2:0][W-1:0] rows;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sh[r] = t2_acc_q[r][AW-1:FRAC_BITS];
      if (!t2_ok_q) begin
        trans[r] = '0;
      end else if (sh[r][SW-1:W-1] == {(SW-W+1){sh[r][SW-1]}}) begin
        trans[r] = sh[r][W-1:0];
      end else begin
        trans[r] = sh[r][SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
      for (int c = 0; c < 3; c++) begin
        if (!t2_ok_q) begin
          rows[r][c] = (r == c) ? (W'(1) << FRAC_BITS) : W'(0);
        end else begin
          rows[r][c] = {{(W-E){t2_row_q[r][c][E-1]}}, t2_row_q[r][c]};
        end
      end
    end
  end

  // valid bits between the normalizers; advance together on adv
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_vld_q <= 1'b0;
      x2_vld_q <= 1'b0;
      t1_vld_q <= 1'b0;
      t2_vld_q <= 1'b0;
    end else if (adv) begin
      x1_vld_q <= nu_valid & f_valid;
      x2_vld_q <= s_valid;
      t1_vld_q <= u_valid;
      t2_vld_q <= t1_vld_q;
    end
  end

  // the whole pipe moves unless its last stage holds a view the sequencer
  // cannot take yet
  assign adv        = !t2_vld_q || rows_ready;
  assign in_ready_o = adv;

  lav_rows #(.WORD_BITS(W)) u_rows (
    .clk_i, .rst_ni,
    .valid_i(t2_vld_q), .ready_o(rows_ready),
    .rows_i(rows), .trans_i(trans), .degenerate_i(!t2_ok_q),
    .out_valid_o, .out_ready_i, .row_index_o,
    .col0_o, .col1_o, .col2_o, .col3_o, .degenerate_o, .last_o
  );

endmodule

### design/lav_check.sv
module lav_check #(
  parameter int WORD_BITS = lav_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [1:0]           row_index_o,
  input logic [WORD_BITS-1:0] col0_o,
  input logic [WORD_BITS-1:0] col3_o,
  input logic                 degenerate_o,
  input logic                 last_o
);

  // hold a stalled row
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_index_o) && $stable(col3_o))
    else $error("stalled row changed");

  // rows of one view follow without gaps
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && (row_index_o == $past(row_index_o) + 2'd1))
    else $error("row sequence broken");

  // a new view starts at the side row
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=>
      !out_valid_o || row_index_o == lav_pkg::ROW_SIDE)
    else $error("view did not restart at side row");

  // degenerate view gives an identity side row
  a_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o && row_index_o == lav_pkg::ROW_SIDE |->
      col0_o == (WORD_BITS'(1) << FRAC_BITS) && col3_o == '0)
    else $error("degenerate row not identity");

endmodule

bind look_at_view_matrix lav_check #(
  .WORD_BITS(WORD_BITS),
  .FRAC_BITS(FRAC_BITS)
) u_lav_check (.*);

### tb/look_at_view_matrix_test.sv
module look_at_view_matrix_test;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam logic [WB-1:0] ONE = 32'h0001_0000;
  localparam logic [WB-1:0] WMAX = 32'h7fff_ffff;
  localparam logic [WB-1:0] WMIN = 32'h8000_0000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 255;
  localparam int CALM_TAIL = 40;

  // One view transaction: eye x,y,z, target x,y,z, up x,y,z.
  typedef struct {
    logic [WB-1:0] w[9];
    bit            ident;  // expected rows typed in as identity
  } view_t;

  typedef struct {
    lav_pkg::row_e idx;
    logic [WB-1:0] c[4];
    logic          degen;
    logic          last;
  } row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic [WB-1:0] view_w[9];
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [1:0]    row_index_o;
  logic [WB-1:0] col0_o, col1_o, col2_o, col3_o;
  logic          degenerate_o, last_o;

  row_t   pending_rows[$];
  int     errors = 0;
  int     cycles = 0;
  bit     calm = 1'b0;
  view_t  directed[$];

  always #6 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < 9; i++) view_w[i] = '0;
  end

  look_at_view_matrix u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .eye_x_i     (view_w[0]),
    .eye_y_i     (view_w[1]),
    .eye_z_i     (view_w[2]),
    .target_x_i  (view_w[3]),
    .target_y_i  (view_w[4]),
    .target_z_i  (view_w[5]),
    .up_x_i      (view_w[6]),
    .up_y_i      (view_w[7]),
    .up_z_i      (view_w[8]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_index_o (row_index_o),
    .col0_o      (col0_o),
    .col1_o      (col1_o),
    .col2_o      (col2_o),
    .col3_o      (col3_o),
    .degenerate_o(degenerate_o),
    .last_o      (last_o)
  );

  // ---------------------------------------------------------------------
  // View matrix predictor
  // ---------------------------------------------------------------------
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Scale to [2^29, 2^30), divide by the rounded-down length with rounding.
  function automatic bit unit_vec(input longint signed vin[3], output longint signed vout[3]);
    longint unsigned v[3], m, r, q;
    bit              neg[3];
    for (int i = 0; i < 3; i++) begin
      neg[i] = vin[i] < 0;
      v[i] = neg[i] ? -vin[i] : vin[i];
      vout[i] = 0;
    end
    m = (v[0] > v[1]) ? v[0] : v[1];
    if (v[2] > m) m = v[2];
    if (m == 0) return 1'b0;
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) v[i] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) v[i] <<= 1;
    end
    r = int_sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((v[i] << FB) + (r >> 1)) / r;
      vout[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic bit cross_unit(input longint signed a[3], input longint signed b[3],
                                    output longint signed o[3]);
    longint signed c[3];
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    return unit_vec(c, o);
  endfunction

  function automatic logic [WB-1:0] sat_word(longint signed v);
    if (v > longint'(32'sh7fff_ffff)) return WMAX;
    if (v < -longint'(64'h8000_0000)) return WMIN;
    return v[WB-1:0];
  endfunction

  function automatic row_t identity_row(int r);
    row_t row;
    row.idx = lav_pkg::row_e'(r);
    for (int i = 0; i < 4; i++) row.c[i] = (i == r) ? ONE : '0;
    row.degen = 1'b1;
    row.last = (r == 2);
    return row;
  endfunction

  // Push the three expected rows of one accepted view.
  task automatic predict_view_rows(input view_t v);
    longint signed eye[3], dir[3], upv[3], nu[3], f[3], s[3], u[3], m[3][3];
    longint signed acc;
    bit            ok;
    row_t          row;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(v.w[i]));
      dir[i] = longint'($signed(v.w[3+i])) - eye[i];
      upv[i] = longint'($signed(v.w[6+i]));
    end
    ok = unit_vec(upv, nu);
    ok = ok && unit_vec(dir, f);
    ok = ok && cross_unit(f, nu, s);
    ok = ok && cross_unit(s, f, u);
    for (int r = 0; r < 3; r++) begin
      if (!ok) begin
        row = identity_row(r);
      end else begin
        for (int i = 0; i < 3; i++) m[r][i] = (r == 0) ? s[i] : (r == 1) ? u[i] : -f[i];
        row.idx = lav_pkg::row_e'(r);
        acc = m[r][0] * eye[0] + m[r][1] * eye[1] + m[r][2] * eye[2];
        acc = (-acc + (64'sd1 <<< (FB - 1))) >>> FB;
        for (int i = 0; i < 3; i++) row.c[i] = sat_word(m[r][i]);
        row.c[3] = sat_word(acc);
        row.degen = 1'b0;
        row.last = (r == 2);
      end
      pending_rows.push_back(row);
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic view_t mk(logic [WB-1:0] ex, ey, ez, tx, ty, tz, ux, uy, uz,
                               bit ident = 1'b0);
    view_t v;
    v.w = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
    v.ident = ident;
    return v;
  endfunction

  function automatic logic [WB-1:0] rand_word(int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 32'h001f_ffff) - 32'h0010_0000;
      default: begin
        case ($urandom_range(0, 5))
          0: return WMAX;
          1: return WMIN;
          2: return '0;
          3: return '1;
          4: return ONE;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  function automatic view_t rand_view();
    view_t v;
    int    sel, kind, k;
    sel = $urandom_range(0, 9);
    kind = (sel < 4) ? 0 : (sel < 7) ? 1 : 2;
    for (int i = 0; i < 9; i++) v.w[i] = rand_word(kind);
    v.ident = 1'b0;
    if (sel == 7) begin
      // target on eye
      for (int i = 0; i < 3; i++) v.w[3+i] = v.w[i];
    end else if (sel == 8) begin
      // up along the view direction, scaled
      k = $urandom_range(0, 1) ? 3 : -2;
      for (int i = 0; i < 3; i++) begin
        v.w[i] = rand_word(1);
        v.w[3+i] = rand_word(1);
        v.w[6+i] = (v.w[3+i] - v.w[i]) * k;
      end
    end
    return v;
  endfunction

  task automatic send_view(input view_t v);
    int gap;
    @(negedge clk_i);
    view_w = v.w;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (v.ident) begin
      for (int r = 0; r < 3; r++) pending_rows.push_back(identity_row(r));
    end else begin
      predict_view_rows(v);
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall bursts, in-order check
  // ---------------------------------------------------------------------
  task automatic check_field(string name, logic [WB-1:0] want, logic [WB-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  initial begin
    int   stall;
    row_t want;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        stall--;
        out_ready_i = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 3) - 1;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = rst_ni;
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_rows.size() == 0) begin
          $error("row transaction with no view pending");
          errors++;
        end else begin
          want = pending_rows.pop_front();
          check_field("row_index", want.idx, row_index_o);
          check_field("col0", want.c[0], col0_o);
          check_field("col1", want.c[1], col1_o);
          check_field("col2", want.c[2], col2_o);
          check_field("col3", want.c[3], col3_o);
          check_field("degenerate", want.degen, degenerate_o);
          check_field("last", want.last, last_o);
        end
      end
    end
  end

  // Hard stop on a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("look_at_view_matrix_test NOT OK");
      $finish;
    end
  end

  initial begin
    int settle;
    // Directed views: degenerate ones carry identity rows typed in.
    directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, ONE, 0, 1));          // target on eye
    directed.push_back(mk(0, 0, 0, 0, 0, -ONE, 0, 0, 0, 1));         // up zero
    directed.push_back(mk(0, 0, 0, 0, ONE, 0, 0, 5 * ONE, 0, 1));    // up along forward
    directed.push_back(mk(0, 0, 0, 0, ONE, 0, 0, -ONE, 0, 1));       // up opposite forward
    directed.push_back(mk(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, 1));
    directed.push_back(mk(0, 0, 0, 0, 0, -ONE, 0, ONE, 0));          // canonical camera
    directed.push_back(mk(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, ONE, 0));
    directed.push_back(mk(WMAX, WMAX, WMAX, WMIN, WMIN, WMIN, 0, 0, ONE));
    directed.push_back(mk(WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, WMAX, 0, WMIN));
    directed.push_back(mk(WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, WMIN, WMAX, WMAX));
    directed.push_back(mk(WMAX, 0, WMIN, 0, WMAX, 0, 1, 0, 0));
    directed.push_back(mk(0, 0, 0, 0, 0, ONE, ONE, 0, 32'h7fff_0000)); // nearly parallel
    directed.push_back(mk(0, 0, 0, 0, 0, ONE, 1, 0, WMAX));          // parallel after scaling
    directed.push_back(mk('1, '1, '1, 1, 1, 1, '1, 1, '1));
    directed.push_back(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, WMIN));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_view(directed[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= N_RANDOM - CALM_TAIL);
      if (n == N_RANDOM / 2) begin
        // hold off until the pipeline has drained
        @(negedge clk_i);
        in_valid_i = 1'b0;
        wait (pending_rows.size() == 0);
      end
      send_view(rand_view());
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    wait (pending_rows.size() == 0);
    // let any stray row show up
    settle = 3 * FB + 200;
    repeat (settle) @(posedge clk_i);
    if (errors == 0 && pending_rows.size() == 0) begin
      $display("look_at_view_matrix_test OK");
    end else begin
      $display("look_at_view_matrix_test NOT OK");
    end
    $finish;
  end

endmodule
